/* rtl/tlf_pkg.sv */
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types and constants for the text line folder.
// ----------------------------------------------------------------------------
`default_nettype none

package tlf_pkg;

  // Line store geometry.
  localparam int LINE_MAX = 32;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int COL_W    = ADDR_W + 1;

  // Field widths fixed by the interface.
  localparam int CHAR_W  = 8;
  localparam int FOLD_W  = 6;
  localparam int STEP_W  = 5;
  localparam int CFG_W   = 6;
  localparam int CFG_A_W = 1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'd32;

  // Configuration register indexes and reset values.
  localparam logic [CFG_A_W-1:0] REG_FOLD_WIDTH = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_TAB_STEP   = 1'd1;
  localparam logic [FOLD_W-1:0]  FOLD_RESET     = 6'd10;
  localparam logic [STEP_W-1:0]  STEP_RESET     = 5'd8;

  // Command kinds passed from the front to the back.
  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_TAB  = 2'd1;
  localparam logic [1:0] CMD_NL   = 2'd2;

  // Depth of the command queue.
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  // Effective (clamped) settings for the back end.
  typedef struct packed {
    logic [COL_W-1:0]  width;
    logic [STEP_W-1:0] step;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/tlf_front.sv */
// ----------------------------------------------------------------------------
// tlf_front
// Holds the configuration registers and classifies incoming bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tlf_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [tlf_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [tlf_pkg::CHAR_W-1:0]    s_tdata,
  input  wire logic                          q_full,
  output logic                               q_push,
  output tlf_pkg::cmd_t                      q_cmd,
  output tlf_pkg::cfg_t                      cfg
);

  logic [tlf_pkg::FOLD_W-1:0] fold_width;
  logic [tlf_pkg::STEP_W-1:0] tab_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_width <= tlf_pkg::FOLD_RESET;
      tab_step   <= tlf_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tlf_pkg::REG_FOLD_WIDTH: fold_width <= cfg_wdata[tlf_pkg::FOLD_W-1:0];
        tlf_pkg::REG_TAB_STEP:   tab_step   <= cfg_wdata[tlf_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Width is clamped into [2, LINE_MAX]; a zero tab step acts as one.
  always_comb begin
    if (fold_width < tlf_pkg::FOLD_W'(2)) begin
      cfg.width = tlf_pkg::COL_W'(2);
    end else if (fold_width > tlf_pkg::FOLD_W'(tlf_pkg::LINE_MAX)) begin
      cfg.width = tlf_pkg::COL_W'(tlf_pkg::LINE_MAX);
    end else begin
      cfg.width = tlf_pkg::COL_W'(fold_width);
    end
    cfg.step = (tab_step == '0) ? tlf_pkg::STEP_W'(1) : tab_step;
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.ch = s_tdata;
    if (s_tdata == tlf_pkg::CHAR_TAB) begin
      q_cmd.kind = tlf_pkg::CMD_TAB;
    end else if (s_tdata == tlf_pkg::CHAR_NL) begin
      q_cmd.kind = tlf_pkg::CMD_NL;
    end else begin
      q_cmd.kind = tlf_pkg::CMD_CHAR;
    end
  end

endmodule

`default_nettype wire

/* rtl/tlf_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// tlf_cmd_fifo
// Short command queue between the classifier and the line sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tlf_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output tlf_pkg::cmd_t      pop_cmd,
  output logic               not_empty
);

  localparam int PTR_W = (tlf_pkg::Q_DEPTH > 1) ? $clog2(tlf_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(tlf_pkg::Q_DEPTH + 1);

  tlf_pkg::cmd_t    entries [tlf_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(tlf_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tlf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tlf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tlf_back.sv */
// ----------------------------------------------------------------------------
// tlf_back
// Line sequencer: line store, column, tab fill, blank search, emit and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tlf_pkg::cfg_t               cfg,
  input  wire logic                        q_valid,
  input  wire tlf_pkg::cmd_t               q_cmd,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [tlf_pkg::CHAR_W-1:0]       m_tdata,
  output logic                             m_tlast
);

  localparam int COL_W  = tlf_pkg::COL_W;
  localparam int ADDR_W = tlf_pkg::ADDR_W;
  localparam int CHAR_W = tlf_pkg::CHAR_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STOP   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;

  logic [2:0]        state, state_next;
  logic [COL_W-1:0]  column, column_next;
  logic [COL_W-1:0]  idx, idx_next;
  logic [COL_W-1:0]  cnt, cnt_next;
  logic [COL_W-1:0]  len, len_next;
  logic [COL_W-1:0]  stop, stop_next;
  logic [ADDR_W-1:0] shift_k, shift_k_next;
  logic              fold, fold_next;

  logic [CHAR_W-1:0] mem [tlf_pkg::LINE_MAX];
  logic [CHAR_W-1:0] rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;

  logic              out_free;
  logic              out_load;
  logic [CHAR_W-1:0] out_char_next;
  logic              out_last_next;

  logic [COL_W-1:0]  pos;
  logic [COL_W-1:0]  pos_inc;
  logic [COL_W-1:0]  idx_inc;
  logic [COL_W-1:0]  tail;

  assign pos = (column >= COL_W'(tlf_pkg::LINE_MAX)) ?
               COL_W'(tlf_pkg::LINE_MAX - 1) : column;
  assign pos_inc  = pos + 1'b1;
  assign idx_inc  = idx + 1'b1;
  assign tail     = len - cnt;
  assign out_free = !m_tvalid || m_tready;

  // The read port follows the next index, so rdata always holds mem[idx].
  assign raddr = idx_next[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

  always_comb begin
    state_next    = state;
    column_next   = column;
    idx_next      = idx;
    cnt_next      = cnt;
    len_next      = len;
    stop_next     = stop;
    shift_k_next  = shift_k;
    fold_next     = fold;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = idx[ADDR_W-1:0];
    wdata         = tlf_pkg::CHAR_BLANK;
    out_load      = 1'b0;
    out_char_next = rdata;
    out_last_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            tlf_pkg::CMD_TAB: begin
              stop_next  = COL_W'(cfg.step);
              idx_next   = pos;
              state_next = S_STOP;
            end
            tlf_pkg::CMD_NL: begin
              column_next = '0;
              if (pos != '0) begin
                cnt_next   = pos;
                idx_next   = '0;
                fold_next  = 1'b0;
                state_next = S_EMIT;
              end
            end
            default: begin
              we    = 1'b1;
              waddr = pos[ADDR_W-1:0];
              wdata = q_cmd.ch;
              if (pos_inc >= cfg.width) begin
                len_next   = pos_inc;
                idx_next   = pos;
                state_next = S_SEARCH;
              end else begin
                column_next = pos_inc;
              end
            end
          endcase
        end
      end

      // Find the first tab stop above the starting column.
      S_STOP: begin
        if (stop <= idx) begin
          stop_next = stop + COL_W'(cfg.step);
        end else begin
          state_next = S_FILL;
        end
      end

      S_FILL: begin
        we       = 1'b1;
        waddr    = idx[ADDR_W-1:0];
        wdata    = tlf_pkg::CHAR_BLANK;
        idx_next = idx_inc;
        if (idx_inc >= cfg.width) begin
          cnt_next    = idx_inc;
          idx_next    = '0;
          fold_next   = 1'b0;
          column_next = '0;
          state_next  = S_EMIT;
        end else if (idx_inc >= stop) begin
          column_next = idx_inc;
          state_next  = S_IDLE;
        end
      end

      // Scan down from the newest byte; a blank at index zero does not count.
      S_SEARCH: begin
        if (idx == '0) begin
          cnt_next   = cfg.width - 1'b1;
          idx_next   = '0;
          fold_next  = 1'b1;
          state_next = S_EMIT;
        end else if (rdata == tlf_pkg::CHAR_BLANK) begin
          cnt_next   = idx_inc;
          idx_next   = '0;
          fold_next  = 1'b1;
          state_next = S_EMIT;
        end else begin
          idx_next = idx - 1'b1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx < cnt) begin
            out_char_next = rdata;
            idx_next      = idx_inc;
          end else begin
            out_char_next = tlf_pkg::CHAR_NL;
            out_last_next = 1'b1;
            if (fold && (cnt < len)) begin
              idx_next     = cnt;
              shift_k_next = '0;
              state_next   = S_SHIFT;
            end else begin
              column_next = '0;
              state_next  = S_IDLE;
            end
          end
        end
      end

      // Move the carried-over tail to the front of the store.
      S_SHIFT: begin
        we           = 1'b1;
        waddr        = shift_k;
        wdata        = rdata;
        idx_next     = idx_inc;
        shift_k_next = shift_k + 1'b1;
        if (COL_W'(shift_k) + 1'b1 == tail) begin
          column_next = tail;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      column   <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      column <= column_next;
      idx    <= idx_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    len     <= len_next;
    stop    <= stop_next;
    shift_k <= shift_k_next;
    fold    <= fold_next;
    if (out_load) begin
      m_tdata <= out_char_next;
      m_tlast <= out_last_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/text_line_folder.sv */
// ----------------------------------------------------------------------------
// text_line_folder
// Folds a byte stream into lines of bounded width and expands tabs.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload                     Handshake
// s_*      in         tdata[7:0] = in_char        tvalid/tready
// m_*      out        tdata[7:0] = out_char,      tvalid/tready
//                     tlast = run_last
// cfg_*    in         index 0 fold_width,         cfg_we, no wait
//                     index 1 tab_step
//
// An ordinary byte that does not fold is written straight into the line
// store; a newline emits the stored bytes and a line end. A fold scans down
// for a blank one stored byte at a time, emits the line and then moves the
// tail byte by byte, as set by the single read port of the line store. A tab
// steps past each tab stop at or below the column, writes one blank per
// column up to the next stop, then flushes the line if it fills.
// Reset is synchronous and needs no clearing pass; output stalls hold the
// sequencer while the two-entry command queue keeps accepting input.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_folder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tlf_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [tlf_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] in_char
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [7:0]                         m_tdata,   // [7:0] out_char
  output logic                               m_tlast    // run_last
);

  tlf_pkg::cmd_t push_cmd;
  tlf_pkg::cmd_t pop_cmd;
  tlf_pkg::cfg_t cfg;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;

  tlf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .cfg       (cfg)
  );

  tlf_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  tlf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

/* rtl/tlf_checker.sv */
// ----------------------------------------------------------------------------
// tlf_checker
// Port-level checks for the text line folder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [7:0]                    m_tdata,
  input wire logic                          m_tlast
);

  // A stalled output transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  // Nothing is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Every run of output ends in a line end.
  a_last_is_nl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == tlf_pkg::CHAR_NL)
    else $error("last byte of a run is not a newline");

  // Stored line bytes are never tabs or newlines.
  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |->
      m_tdata != tlf_pkg::CHAR_NL && m_tdata != tlf_pkg::CHAR_TAB)
    else $error("tab or newline inside a folded line");

endmodule

bind text_line_folder tlf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the line folder against its own prediction of every emitted byte.
// Text and random bytes stream in under several fold and tab settings. Both
// stream sides stall at random, and every output transaction is compared with
// the oldest predicted byte.
// ----------------------------------------------------------------------------

module testbench;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [tlf_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } folded_byte_t;

  // Mirrors the folder state and holds the bytes it must emit, oldest first.
  class fold_checker;
    logic [tlf_pkg::CHAR_W-1:0] line_buf [tlf_pkg::LINE_MAX];
    int                         column;
    logic [tlf_pkg::FOLD_W-1:0] fold_w;
    logic [tlf_pkg::STEP_W-1:0] tab_w;
    folded_byte_t               folded_bytes[$];
    int                         failures;

    function new();
      column   = 0;
      fold_w   = tlf_pkg::FOLD_RESET;
      tab_w    = tlf_pkg::STEP_RESET;
      failures = 0;
      foreach (line_buf[i]) line_buf[i] = '0;
    endfunction

    function void fault(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function int pending();
      return folded_bytes.size();
    endfunction

    function void set_reg(logic [tlf_pkg::CFG_A_W-1:0] idx,
                          logic [tlf_pkg::CFG_W-1:0] val);
      if (idx == tlf_pkg::REG_FOLD_WIDTH) fold_w = val[tlf_pkg::FOLD_W-1:0];
      else if (idx == tlf_pkg::REG_TAB_STEP) tab_w = val[tlf_pkg::STEP_W-1:0];
    endfunction

    // Queues the first count stored bytes followed by a line end.
    function void push_line(int count);
      folded_byte_t fb;
      fb.last = 1'b0;
      for (int i = 0; i < count && i < tlf_pkg::LINE_MAX; i++) begin
        fb.ch = line_buf[i];
        folded_bytes.push_back(fb);
      end
      fb.ch = tlf_pkg::CHAR_NL;
      folded_bytes.push_back(fb);
    endfunction

    function void note_input(logic [tlf_pkg::CHAR_W-1:0] c);
      int w;
      int t;
      int pos;
      int brk;
      int tail;
      int first;
      w = fold_w;
      if (w < 2) w = 2;
      if (w > tlf_pkg::LINE_MAX) w = tlf_pkg::LINE_MAX;
      t = (tab_w == 0) ? 1 : int'(tab_w);
      pos = column;
      if (pos >= tlf_pkg::LINE_MAX) pos = tlf_pkg::LINE_MAX - 1;
      first = folded_bytes.size();
      if (c == tlf_pkg::CHAR_TAB) begin
        line_buf[pos] = tlf_pkg::CHAR_BLANK;
        pos++;
        while (pos < w && (pos % t) != 0) begin
          line_buf[pos] = tlf_pkg::CHAR_BLANK;
          pos++;
        end
        if (pos >= w) begin
          push_line(pos);
          pos = 0;
        end
      end else if (c == tlf_pkg::CHAR_NL) begin
        if (pos > 0) push_line(pos);
        pos = 0;
      end else begin
        line_buf[pos] = c;
        pos++;
        if (pos >= w) begin
          // Break after the last blank past the first byte, else at width-1.
          brk = w - 1;
          for (int i = pos - 1; i > 0; i--) begin
            if (line_buf[i] == tlf_pkg::CHAR_BLANK) begin
              brk = i + 1;
              break;
            end
          end
          push_line(brk);
          if (brk >= pos) begin
            pos = 0;
          end else begin
            tail = pos - brk;
            for (int i = 0; i < tail; i++) line_buf[i] = line_buf[brk + i];
            pos = tail;
          end
        end
      end
      column = pos;
      if (folded_bytes.size() > first) folded_bytes[folded_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(logic [tlf_pkg::CHAR_W-1:0] ch, logic last);
      folded_byte_t want;
      if (folded_bytes.size() == 0) begin
        fault($sformatf("unexpected output byte %02h run_last %0b", ch, last));
        return;
      end
      want = folded_bytes.pop_front();
      if (want.ch !== ch || want.last !== last)
        fault($sformatf("out_char expected %02h got %02h, run_last expected %0b got %0b",
                        want.ch, ch, want.last, last));
    endfunction
  endclass

  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic [tlf_pkg::CFG_A_W-1:0] cfg_addr  = '0;
  logic [tlf_pkg::CFG_W-1:0]   cfg_wdata = '0;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [7:0]                  s_tdata   = '0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [7:0]                  m_tdata;
  logic                        m_tlast;

  bit                 quiet = 1'b0;
  int                 stall_cycles = 0;
  fold_checker        folder = new();

  text_line_folder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side back-pressure: short random stalls, long ready stretches now
  // and then, and none once the run turns quiet.
  initial begin
    @(posedge clk);
    forever begin
      if (quiet) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(30, 60)) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) folder.set_reg(cfg_addr, cfg_wdata);
      if (s_tvalid && s_tready) folder.note_input(s_tdata);
      if (m_tvalid && m_tready) folder.check_byte(m_tdata, m_tlast);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_char(int nl_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < nl_pct) return tlf_pkg::CHAR_NL;
    if (r < nl_pct + 7) return tlf_pkg::CHAR_TAB;
    if (r < nl_pct + 25) return tlf_pkg::CHAR_BLANK;
    if (r < nl_pct + 35) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  // Holds the byte until the transaction completes; tvalid is only lowered
  // for an idle burst, never in the step that raises it again.
  task automatic send_char(input logic [7:0] c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Waits for every predicted byte, then lets a byte that emits nothing
  // finish inside the block.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (folder.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int nl_pct);
    for (int i = 0; i < count; i++) send_char(pick_char(nl_pct));
    drain();
  endtask

  task automatic set_layout(input logic [tlf_pkg::CFG_W-1:0] fold,
                            input logic [tlf_pkg::CFG_W-1:0] tab);
    cfg_we    <= 1'b1;
    cfg_addr  <= tlf_pkg::REG_FOLD_WIDTH;
    cfg_wdata <= fold;
    @(posedge clk);
    cfg_addr  <= tlf_pkg::REG_TAB_STEP;
    cfg_wdata <= tab;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: empty line end, a tab that stops short, a fold at the
    // last blank, zero and high bytes, a tab that fills the line, and a run
    // with no blank at all.
    send_text("\nAB\tCD\n");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(tlf_pkg::CHAR_BLANK);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(tlf_pkg::CHAR_NL);
    send_text("\t\txxxxxxxxxx");
    run_phase(30, 10);

    set_layout(6'd2, 6'd1);
    run_phase(25, 10);
    set_layout(6'd32, 6'd16);
    run_phase(30, 2);

    // Narrow the width under a long stored line: the next byte folds over
    // the whole run, its tail outgrows the width, and a tab flushes it at once.
    send_text("\nabcdefgh ijklmnop qrstuv");
    drain();
    set_layout(6'd4, 6'd0);
    send_text("w\txyzab\n");
    drain();

    // Out of range settings are clamped by the block.
    set_layout(6'd0, 6'd0);
    run_phase(25, 10);
    set_layout(6'd63, 6'h3F);
    run_phase(30, 3);
    set_layout(6'd1, 6'd5);
    run_phase(20, 10);

    repeat (2) begin
      set_layout(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      run_phase(20, 8);
    end

    quiet = 1'b1;
    set_layout(6'd10, 6'd4);
    run_phase(30, 8);

    if (folder.pending() != 0)
      folder.fault($sformatf("%0d output bytes never arrived", folder.pending()));
    if (folder.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
